@@ rtl/core/pfat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfat_pkg
// Shared types and codes for the paged frame allocator and translator.
// ----------------------------------------------------------------------------
package pfat_pkg;

    localparam int VA_W     = 32;
    localparam int VPN_W    = 8;
    localparam int OFF_W    = 8;
    localparam int PPP_W    = 9;
    localparam int FIDX_W   = 7;
    localparam int PFN_W    = 7;
    localparam int PA_W     = 15;
    localparam int FREE_W   = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESERVE = 2'd0,
        MODE_LOAD    = 2'd1,
        MODE_XLATE   = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_XLATED     = 3'd0,
        ST_VA_RANGE   = 3'd1,
        ST_VPN_RANGE  = 3'd2,
        ST_UNMAPPED   = 3'd3,
        ST_LOADED     = 3'd4,
        ST_REFUSED    = 3'd5,
        ST_RESERVED   = 3'd6,
        ST_FRAME_BUSY = 3'd7
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic respond;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_go;
        logic xlate_go;
        logic scan_last;
    } t_dp_sts;

endpackage

@@ rtl/core/pfat_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfat_ctrl
// Sequencer: accept, execute, frame scan for loads, table read for hits.
// ----------------------------------------------------------------------------
module pfat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pfat_pkg::t_dp_sts i_sts,
    output pfat_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.load_go) begin
                    n_state = S_SCAN;
                end else if (i_sts.xlate_go) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy          = r_busy;
    assign o_cmd.capture = start && !r_busy;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.scan    = (r_state == S_SCAN);
    assign o_cmd.respond = (r_state == S_RESP);

endmodule

@@ rtl/core/pfat_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfat_dp
// Frame map, free count, page table memory, fill counts and result registers.
// ----------------------------------------------------------------------------
module pfat_dp #(
    parameter int FRAMES    = 128,
    parameter int PROCESSES = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfat_pkg::t_dp_cmd               i_cmd,
    output pfat_pkg::t_dp_sts               o_sts,
    input  logic                            i_cfg_wr_en,
    input  logic [pfat_pkg::PPP_W-1:0]      i_cfg_wr_data,
    input  logic [pfat_pkg::MODE_W-1:0]     i_mode,
    input  logic                            i_process,
    input  logic [pfat_pkg::VA_W-1:0]       i_virtual_address,
    input  logic [pfat_pkg::FIDX_W-1:0]     i_frame_index,
    output logic                            o_done,
    output logic [pfat_pkg::STATUS_W-1:0]   o_status,
    output logic [pfat_pkg::PA_W-1:0]       o_phys_addr,
    output logic [pfat_pkg::VPN_W-1:0]      o_page_number,
    output logic [pfat_pkg::OFF_W-1:0]      o_page_offset,
    output logic [pfat_pkg::PFN_W-1:0]      o_frame_number,
    output logic [pfat_pkg::FREE_W-1:0]     o_free_frames
);

    localparam int FI_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PROC_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PROC_N = 1 << PROC_W;
    localparam int AW     = PROC_W + pfat_pkg::VPN_W;
    localparam int CNT_W  = pfat_pkg::PPP_W;

    // captured item
    logic [pfat_pkg::MODE_W-1:0]   r_mode;
    logic                          r_proc;
    logic [pfat_pkg::VA_W-1:0]     r_va;
    logic [pfat_pkg::FIDX_W-1:0]   r_fidx;

    // control state
    logic [CNT_W-1:0]              r_ppp;
    logic [FRAMES-1:0]             r_map;      // set: frame owned
    logic [CNT_W-1:0]              r_free;
    logic [CNT_W-1:0]              r_loaded [PROC_N];
    logic                          r_done;

    // scan state and table
    logic [FI_W-1:0]               r_f;
    logic [CNT_W-1:0]              r_cnt;
    logic [FI_W-1:0]               r_mem [PROC_N * 256];
    logic [FI_W-1:0]               r_rd;

    // result registers
    logic [pfat_pkg::STATUS_W-1:0] r_status;
    logic [pfat_pkg::PA_W-1:0]     r_pa;
    logic [pfat_pkg::VPN_W-1:0]    r_vpn;
    logic [pfat_pkg::OFF_W-1:0]    r_off;
    logic [pfat_pkg::PFN_W-1:0]    r_pfn;

    pfat_pkg::t_mode               mode;
    logic [PROC_W:0]               proc_ext;
    logic [PROC_W-1:0]             proc_idx;
    logic [8:0]                    fidx_ext;
    logic [FI_W-1:0]               fidx_idx;
    logic                          proc_ok;
    logic                          fidx_ok;
    logic                          rsv_ok;
    logic                          load_ok;
    logic [pfat_pkg::VPN_W-1:0]    vpn;
    logic [pfat_pkg::OFF_W-1:0]    off;
    logic                          va_ok;
    logic                          vpn_ok;
    logic                          xlate_hit;
    logic                          scan_free;
    logic [8:0]                    pfn_ext;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic [pfat_pkg::STATUS_W-1:0] n_status;
    logic [pfat_pkg::VPN_W-1:0]    n_vpn;
    logic [pfat_pkg::OFF_W-1:0]    n_off;

    always_comb begin
        mode      = pfat_pkg::t_mode'(r_mode);
        proc_ext  = (PROC_W + 1)'(r_proc);
        proc_idx  = proc_ext[PROC_W-1:0];
        fidx_ext  = 9'(r_fidx);
        fidx_idx  = fidx_ext[FI_W-1:0];
        proc_ok   = (32'(r_proc) < PROCESSES);
        fidx_ok   = (32'(r_fidx) < FRAMES);
        rsv_ok    = fidx_ok && !r_map[fidx_idx];
        load_ok   = proc_ok && (r_ppp <= r_free);
        vpn       = r_va[15:8];
        off       = r_va[7:0];
        va_ok     = (r_va[pfat_pkg::VA_W-1:16] == '0);
        vpn_ok    = (CNT_W'(vpn) < r_ppp);
        // a page is valid when some earlier load covered it
        xlate_hit = va_ok && vpn_ok && proc_ok && (CNT_W'(vpn) < r_loaded[proc_idx]);
        scan_free = !r_map[r_f];
        pfn_ext   = 9'(r_rd);
        waddr     = {proc_idx, r_cnt[pfat_pkg::VPN_W-1:0]};
        raddr     = {proc_idx, vpn};
    end

    assign o_sts.load_go   = (mode == pfat_pkg::MODE_LOAD) && load_ok && (r_ppp != '0);
    assign o_sts.xlate_go  = (mode == pfat_pkg::MODE_XLATE) && xlate_hit;
    assign o_sts.scan_last = scan_free && ((r_cnt + CNT_W'(1)) == r_ppp);

    always_comb begin
        n_status = pfat_pkg::ST_REFUSED;
        n_vpn    = '0;
        n_off    = '0;
        case (mode)
            pfat_pkg::MODE_RESERVE: begin
                n_status = rsv_ok ? pfat_pkg::ST_RESERVED : pfat_pkg::ST_FRAME_BUSY;
            end
            pfat_pkg::MODE_LOAD: begin
                n_status = load_ok ? pfat_pkg::ST_LOADED : pfat_pkg::ST_REFUSED;
            end
            pfat_pkg::MODE_XLATE: begin
                if (!va_ok) begin
                    n_status = pfat_pkg::ST_VA_RANGE;
                end else begin
                    n_vpn = vpn;
                    n_off = off;
                    n_status = vpn_ok ? pfat_pkg::ST_UNMAPPED : pfat_pkg::ST_VPN_RANGE;
                end
            end
            default: begin
                n_status = pfat_pkg::ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppp  <= '0;
            r_map  <= '0;
            r_free <= CNT_W'(FRAMES);
            r_done <= 1'b0;
            for (int p = 0; p < PROC_N; p++) begin
                r_loaded[p] <= '0;
            end
        end else begin
            r_done <= (i_cmd.exec && !(o_sts.load_go || o_sts.xlate_go))
                   || (i_cmd.scan && o_sts.scan_last)
                   || i_cmd.respond;
            if (i_cfg_wr_en) begin
                r_ppp <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                if (mode == pfat_pkg::MODE_RESERVE && rsv_ok) begin
                    r_map[fidx_idx] <= 1'b1;
                    r_free          <= r_free - CNT_W'(1);
                end
                if (mode == pfat_pkg::MODE_LOAD && load_ok && r_ppp > r_loaded[proc_idx]) begin
                    r_loaded[proc_idx] <= r_ppp;
                end
            end
            if (i_cmd.scan && scan_free) begin
                r_map[r_f] <= 1'b1;
                r_free     <= r_free - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_proc <= i_process;
            r_va   <= i_virtual_address;
            r_fidx <= i_frame_index;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_vpn    <= n_vpn;
            r_off    <= n_off;
            r_pfn    <= '0;
            r_pa     <= '0;
            r_f      <= '0;
            r_cnt    <= '0;
        end
        if (i_cmd.scan) begin
            // advance one frame per cycle, take it when free
            r_f <= r_f + FI_W'(1);
            if (scan_free) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (o_sts.scan_last) begin
                r_status <= pfat_pkg::ST_LOADED;
            end
        end
        if (i_cmd.respond) begin
            r_status <= pfat_pkg::ST_XLATED;
            r_pfn    <= pfn_ext[pfat_pkg::PFN_W-1:0];
            r_pa     <= {pfn_ext[pfat_pkg::PFN_W-1:0], r_off};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && scan_free) begin
            r_mem[waddr] <= r_f;
        end
        if (i_cmd.exec && o_sts.xlate_go) begin
            r_rd <= r_mem[raddr];
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_phys_addr    = r_pa;
    assign o_page_number  = r_vpn;
    assign o_page_offset  = r_off;
    assign o_frame_number = r_pfn;
    assign o_free_frames  = r_free[pfat_pkg::FREE_W-1:0];

endmodule

@@ rtl/core/paged_frame_allocator_translator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_frame_allocator_translator_top
// Frame reservation, process page table load and address translation.
// ----------------------------------------------------------------------------
// Sequence: start is captured, then an execute state answers reserve, refused
//   or empty load, mode 3 and failed translations; a translation hit first
//   passes a response state (one page table read), a load a frame scan state.
// Throughput: one item in flight; start is taken again in the result beat cycle.
//   The receiver cannot stall.
// Reset: synchronous; all frames free, no pages mapped, register cleared.
module paged_frame_allocator_translator_top #(
    parameter int FRAMES    = 128,
    parameter int PROCESSES = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_wr_en,
    input  logic [pfat_pkg::PPP_W-1:0]      i_cfg_wr_data,
    input  logic [pfat_pkg::MODE_W-1:0]     i_mode,
    input  logic                            i_process,
    input  logic [pfat_pkg::VA_W-1:0]       i_virtual_address,
    input  logic [pfat_pkg::FIDX_W-1:0]     i_frame_index,
    output logic                            o_done,
    output logic [pfat_pkg::STATUS_W-1:0]   o_status,
    output logic [pfat_pkg::PA_W-1:0]       o_phys_addr,
    output logic [pfat_pkg::VPN_W-1:0]      o_page_number,
    output logic [pfat_pkg::OFF_W-1:0]      o_page_offset,
    output logic [pfat_pkg::PFN_W-1:0]      o_frame_number,
    output logic [pfat_pkg::FREE_W-1:0]     o_free_frames
);

    pfat_pkg::t_dp_cmd cmd;
    pfat_pkg::t_dp_sts sts;

    pfat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pfat_dp #(
        .FRAMES    (FRAMES),
        .PROCESSES (PROCESSES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_mode             (i_mode),
        .i_process          (i_process),
        .i_virtual_address  (i_virtual_address),
        .i_frame_index      (i_frame_index),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_phys_addr        (o_phys_addr),
        .o_page_number      (o_page_number),
        .o_page_offset      (o_page_offset),
        .o_frame_number     (o_frame_number),
        .o_free_frames      (o_free_frames)
    );

endmodule

@@ rtl/core/pfat_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfat_chk
// Port-level checks for the allocator/translator, bound to the top level.
// ----------------------------------------------------------------------------
module pfat_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            o_done,
    input  logic [pfat_pkg::STATUS_W-1:0]   o_status,
    input  logic [pfat_pkg::PA_W-1:0]       o_phys_addr,
    input  logic [pfat_pkg::VPN_W-1:0]      o_page_number,
    input  logic [pfat_pkg::OFF_W-1:0]      o_page_offset,
    input  logic [pfat_pkg::PFN_W-1:0]      o_frame_number
);

    // no result beat in the cycle right after an accepted item
    a_no_early_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result beat one cycle after accept");

    // the result beat arrives with the block ready again
    a_idle_at_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy high during result beat");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result beats");

    a_pa_compose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == pfat_pkg::ST_XLATED) |->
        (o_phys_addr[7:0] == o_page_offset &&
         o_phys_addr[14:8] == o_frame_number))
        else $error("physical address does not match frame and offset");

    a_va_range_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == pfat_pkg::ST_VA_RANGE) |->
        (o_page_number == '0 && o_page_offset == '0 && o_phys_addr == '0))
        else $error("out-of-range address reports page fields");

endmodule

bind paged_frame_allocator_translator_top pfat_chk u_pfat_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged frame allocator and translator. Frame
// reservations, process loads and address translations go in through the
// start/busy handshake. A scoreboard keeps its own frame ownership map and
// page tables, predicts each answer and checks every result beat, field by
// field. Both directed cases and constrained-by-hand random traffic are used,
// across several page-count settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pfat_pkg::*;

    localparam int FRAME_COUNT = 128;
    localparam int PROC_COUNT  = 2;
    localparam int VPAGE_COUNT = 256;
    localparam int PHASE_ITEMS = 145;
    localparam int TAIL_ITEMS  = 60;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] OWNER_FREE   = 2'd0;
    localparam logic [1:0] OWNER_SYSTEM = 2'd1;
    localparam logic [1:0] OWNER_PROC0  = 2'd2;

    typedef struct {
        t_status             status;
        logic [PA_W-1:0]     phys_addr;
        logic [VPN_W-1:0]    vpn;
        logic [OFF_W-1:0]    offset;
        logic [PFN_W-1:0]    pfn;
        logic [FREE_W-1:0]   free_cnt;
    } t_answer;

    class pfat_scoreboard;
        int unsigned      errors;
        int unsigned      free_total;
        int unsigned      pages;
        logic [1:0]       frame_owner [FRAME_COUNT];
        bit               page_valid [PROC_COUNT][VPAGE_COUNT];
        logic [PFN_W-1:0] page_frame [PROC_COUNT][VPAGE_COUNT];
        t_answer          answer_q [$];

        function new();
            errors     = 0;
            free_total = FRAME_COUNT;
            pages      = 0;
            foreach (frame_owner[f]) frame_owner[f] = OWNER_FREE;
            foreach (page_valid[p, v]) begin
                page_valid[p][v] = 1'b0;
                page_frame[p][v] = '0;
            end
        endfunction

        function void set_pages(int unsigned n);
            pages = n;
        endfunction

        function int unsigned pending();
            return answer_q.size();
        endfunction

        // Predict the answer to one accepted command and update the frame map.
        function void note_command(logic [MODE_W-1:0] mode, logic proc,
                                   logic [VA_W-1:0] va, logic [FIDX_W-1:0] fidx);
            t_answer     a;
            int unsigned f;
            a.status    = ST_REFUSED;
            a.phys_addr = '0;
            a.vpn       = '0;
            a.offset    = '0;
            a.pfn       = '0;
            f           = 0;
            case (mode)
                MODE_RESERVE: begin
                    if (frame_owner[fidx] == OWNER_FREE) begin
                        frame_owner[fidx] = OWNER_SYSTEM;
                        free_total--;
                        a.status = ST_RESERVED;
                    end else begin
                        a.status = ST_FRAME_BUSY;
                    end
                end
                MODE_LOAD: begin
                    if (pages <= free_total) begin
                        // map pages in order onto the lowest free frames
                        for (int unsigned i = 0; i < pages; i++) begin
                            while (f < FRAME_COUNT && frame_owner[f] != OWNER_FREE) f++;
                            frame_owner[f] = OWNER_PROC0 + proc;
                            free_total--;
                            page_valid[proc][i] = 1'b1;
                            page_frame[proc][i] = PFN_W'(f);
                            f++;
                        end
                        a.status = ST_LOADED;
                    end
                end
                MODE_XLATE: begin
                    if (va > 32'h0000_FFFF) begin
                        a.status = ST_VA_RANGE;
                    end else begin
                        a.offset = va[7:0];
                        a.vpn    = va[15:8];
                        if (a.vpn >= pages) begin
                            a.status = ST_VPN_RANGE;
                        end else if (page_valid[proc][a.vpn]) begin
                            a.pfn       = page_frame[proc][a.vpn];
                            a.phys_addr = {a.pfn, a.offset};
                            a.status    = ST_XLATED;
                        end else begin
                            a.status = ST_UNMAPPED;
                        end
                    end
                end
                default: a.status = ST_REFUSED;
            endcase
            a.free_cnt = FREE_W'(free_total);
            answer_q.push_back(a);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_answer(logic [STATUS_W-1:0] status, logic [PA_W-1:0] phys_addr,
                                   logic [VPN_W-1:0] vpn, logic [OFF_W-1:0] offset,
                                   logic [PFN_W-1:0] pfn, logic [FREE_W-1:0] free_cnt);
            t_answer a;
            if (answer_q.size() == 0) begin
                $error("result beat with no command outstanding (status %0d)", status);
                errors++;
                return;
            end
            a = answer_q.pop_front();
            compare_field("status", a.status, status);
            compare_field("phys_addr", a.phys_addr, phys_addr);
            compare_field("page_number", a.vpn, vpn);
            compare_field("page_offset", a.offset, offset);
            compare_field("frame_number", a.pfn, pfn);
            compare_field("free_frames", a.free_cnt, free_cnt);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_cfg_wr_en;
    logic [PPP_W-1:0]       i_cfg_wr_data;
    logic [MODE_W-1:0]      i_mode;
    logic                   i_process;
    logic [VA_W-1:0]        i_virtual_address;
    logic [FIDX_W-1:0]      i_frame_index;
    logic                   o_done;
    logic [STATUS_W-1:0]    o_status;
    logic [PA_W-1:0]        o_phys_addr;
    logic [VPN_W-1:0]       o_page_number;
    logic [OFF_W-1:0]       o_page_offset;
    logic [PFN_W-1:0]       o_frame_number;
    logic [FREE_W-1:0]      o_free_frames;

    pfat_scoreboard sb = new();
    int unsigned    beats_sent = 0;
    bit             steady     = 1'b0;
    int unsigned    phase_pages [6] = '{1, 4, 8, 12, 2, 6};

    paged_frame_allocator_translator_top #(
        .FRAMES    (FRAME_COUNT),
        .PROCESSES (PROC_COUNT)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_mode             (i_mode),
        .i_process          (i_process),
        .i_virtual_address  (i_virtual_address),
        .i_frame_index      (i_frame_index),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_phys_addr        (o_phys_addr),
        .o_page_number      (o_page_number),
        .o_page_offset      (o_page_offset),
        .o_frame_number     (o_frame_number),
        .o_free_frames      (o_free_frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_answer(o_status, o_phys_addr, o_page_number,
                            o_page_offset, o_frame_number, o_free_frames);
        end
    end

    // Present one command and hold it until the block takes the beat.
    task automatic issue(input logic [MODE_W-1:0] mode, input logic proc,
                         input logic [VA_W-1:0] va, input logic [FIDX_W-1:0] fidx);
        int unsigned gap;
        if (beats_sent % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_mode            <= mode;
        i_process         <= proc;
        i_virtual_address <= va;
        i_frame_index     <= fidx;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_command(mode, proc, va, fidx);
        beats_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_pages(input int unsigned n);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= PPP_W'(n);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_pages(n);
        @(posedge i_clk);
    endtask

    // Mostly in-range pages of the current table; some stray pages and wild addresses.
    function automatic logic [VA_W-1:0] pick_address(int unsigned pages);
        int unsigned     r;
        logic [VA_W-1:0] va;
        r  = $urandom_range(0, 99);
        va = $urandom;
        if (r < 80 && pages != 0) begin
            va = {16'h0000, 8'($urandom_range(0, pages - 1)), 8'($urandom)};
        end else if (r < 92) begin
            va = {16'h0000, va[15:0]};
        end
        return va;
    endfunction

    task automatic random_item();
        int unsigned       r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, 99);
        if (r < 3) mode = MODE_LOAD;
        else if (r < 9) mode = MODE_RESERVE;
        else if (r < 11) mode = MODE_UNUSED;
        else mode = MODE_XLATE;
        issue(mode, 1'($urandom), pick_address(sb.pages), 7'($urandom));
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        i_mode            <= MODE_RESERVE;
        i_process         <= 1'b0;
        i_virtual_address <= '0;
        i_frame_index     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // page limit still zero: every in-range address is beyond it
        issue(MODE_XLATE, 1'b0, 32'h0000_0000, 7'd0);
        issue(MODE_XLATE, 1'b1, 32'hFFFF_FFFF, 7'h7F);
        issue(MODE_XLATE, 1'b0, 32'h0001_0000, 7'd0);
        issue(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF, 7'h7F);
        issue(MODE_RESERVE, 1'b0, 32'h0, 7'd0);
        issue(MODE_RESERVE, 1'b1, 32'h0, 7'd127);
        issue(MODE_RESERVE, 1'b0, 32'h0, 7'd0);
        issue(MODE_LOAD, 1'b0, 32'h0, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_FFFF, 7'd0);

        // more pages than free frames: load refused, tables stay empty
        write_pages(256);
        issue(MODE_LOAD, 1'b1, 32'h0, 7'd0);
        issue(MODE_XLATE, 1'b1, 32'h0000_FFFF, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_0000, 7'd0);

        write_pages(3);
        issue(MODE_LOAD, 1'b0, 32'h0, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_0000, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_02FF, 7'd0);
        issue(MODE_RESERVE, 1'b0, 32'h0, 7'd5);
        // skip the frame just reserved
        issue(MODE_LOAD, 1'b1, 32'h0, 7'd0);
        issue(MODE_XLATE, 1'b1, 32'h0000_01AB, 7'd0);
        // reload takes fresh frames and keeps the old ones owned
        issue(MODE_LOAD, 1'b0, 32'h0, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_0210, 7'd0);
        issue(MODE_XLATE, 1'b0, 32'h0000_0300, 7'd0);
        issue(MODE_RESERVE, 1'b1, 32'h0, 7'd3);
        issue(MODE_XLATE, 1'b1, 32'h0000_FFFF, 7'd0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 3) phase_pages[ph] = $urandom_range(3, 16);
            write_pages(phase_pages[ph]);
            repeat (PHASE_ITEMS) random_item();
        end

        // exact fit: take every remaining frame, then open the full page range
        write_pages(sb.free_total);
        issue(MODE_LOAD, 1'($urandom), 32'h0, 7'd0);
        write_pages(256);
        repeat (TAIL_ITEMS) random_item();

        wait_idle();
        repeat (FRAME_COUNT + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
